// ===== rtl/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants for the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int PIX_W    = 8;
    localparam int WIN_N    = 9;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int MIN_DIM  = 3;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd600;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd800;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } mf3_reg_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic                restart;
    } mf3_cfg_t;

    // pix[0..2] column c-2, pix[3..5] column c-1, pix[6..8] column c, top to bottom
    typedef struct packed {
        logic [WIN_N-1:0][PIX_W-1:0] pix;
        logic                        last;
    } mf3_win_t;

endpackage

// ===== rtl/mf3_pixel_if.sv =====
// ----------------------------------------------------------------------------
// mf3_pixel_if
// Pixel stream channel: valid/ready handshake with one grayscale pixel.
// ----------------------------------------------------------------------------
interface mf3_pixel_if
    import mf3_pkg::*;
();

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);

endinterface

// ===== rtl/mf3_result_if.sv =====
// ----------------------------------------------------------------------------
// mf3_result_if
// Result channel: valid/ready handshake with median and end-of-frame flag.
// ----------------------------------------------------------------------------
interface mf3_result_if
    import mf3_pkg::*;
();

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] median;
    logic             frame_last;

    modport source (output valid, output median, output frame_last, input ready);
    modport sink   (input valid, input median, input frame_last, output ready);

endinterface

// ===== rtl/mf3_cfg.sv =====
// ----------------------------------------------------------------------------
// mf3_cfg
// APB register file: image width and height, frame restart on any write.
// ----------------------------------------------------------------------------
module mf3_cfg
    import mf3_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output mf3_cfg_t              cfg
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                wr_en;
    mf3_reg_t            reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = mf3_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // counters restart at the same edge as the register write
    assign cfg.width   = width_reg;
    assign cfg.height  = height_reg;
    assign cfg.restart = wr_en;

endmodule

// ===== rtl/mf3_window.sv =====
// ----------------------------------------------------------------------------
// mf3_window
// Raster counters, line memory and 3x3 window; two pipeline stages.
// ----------------------------------------------------------------------------
module mf3_window
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mf3_cfg_t    cfg,
    mf3_pixel_if.sink   pixels,
    output logic        win_valid,
    input  logic        win_ready,
    output mf3_win_t    win
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ? $clog2(MAX_WIDTH + 1) : WIDTH_W;

    // one word per column: {row r-2, row r-1}
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

    logic [WW-1:0]       width_ext;
    logic [WW-1:0]       width_eff;
    logic [HEIGHT_W-1:0] height_eff;
    logic [CW-1:0]       col_last;
    logic [HEIGHT_W-1:0] row_last;

    logic [CW-1:0]       col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;

    logic               s1_valid_reg;
    logic [PIX_W-1:0]   s1_px_reg;
    logic [CW-1:0]      s1_addr_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    logic [2*PIX_W-1:0] line_rd_reg;

    logic [5:0][PIX_W-1:0] shift_reg;

    logic     s2_valid_reg;
    mf3_win_t s2_win_reg;

    logic       rdy1, rdy2;
    logic       accept;
    logic       s1_leave;
    mf3_win_t   win_now;
    logic [PIX_W-1:0] top, mid;

    always_comb
    begin
        width_ext = WW'(cfg.width);
        if (width_ext < WW'(MIN_DIM))
            width_eff = WW'(MIN_DIM);
        else if (width_ext > WW'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = width_ext;
        col_last = CW'(width_eff - WW'(1));

        if (cfg.height < HEIGHT_W'(MIN_DIM))
            height_eff = HEIGHT_W'(MIN_DIM);
        else
            height_eff = cfg.height;
        row_last = height_eff - HEIGHT_W'(1);
    end

    assign rdy2     = !s2_valid_reg || win_ready;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s1_leave = s1_valid_reg && rdy2;

    assign pixels.ready = rdy1;
    assign accept       = pixels.valid && rdy1;

    // raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == col_last)
            begin
                col_next = '0;
                row_next = (row_reg == row_last) ? '0 : row_reg + HEIGHT_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line memory: read on transfer, write back when the item leaves stage 1
    always_ff @(posedge clk)
    begin
        if (accept)
            line_rd_reg <= line_mem[col_reg];
        if (s1_leave)
            line_mem[s1_addr_reg] <= {line_rd_reg[PIX_W-1:0], s1_px_reg};
    end

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rdy1)
            s1_valid_reg <= pixels.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= pixels.pixel;
            s1_addr_reg <= col_reg;
            s1_emit_reg <= (row_reg >= HEIGHT_W'(2)) && (col_reg >= CW'(2));
            s1_last_reg <= (row_reg == row_last) && (col_reg == col_last);
        end
    end

    assign top = line_rd_reg[2*PIX_W-1:PIX_W];
    assign mid = line_rd_reg[PIX_W-1:0];

    always_comb
    begin
        win_now.pix[5:0] = shift_reg;
        win_now.pix[6]   = top;
        win_now.pix[7]   = mid;
        win_now.pix[8]   = s1_px_reg;
        win_now.last     = s1_last_reg;
    end

    // stage 2: window columns shift on every item, results only for interior pixels
    always_ff @(posedge clk)
    begin
        if (s1_leave)
        begin
            shift_reg  <= win_now.pix[8:3];
            s2_win_reg <= win_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (rdy2)
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
    end

    assign win_valid = s2_valid_reg;
    assign win       = s2_win_reg;

endmodule

// ===== rtl/mf3_median.sv =====
// ----------------------------------------------------------------------------
// mf3_median
// Three-stage median-of-nine network with output register.
// ----------------------------------------------------------------------------
module mf3_median
    import mf3_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          win_valid,
    output logic          win_ready,
    input  mf3_win_t      win,
    mf3_result_if.source  results
);

    typedef logic [2:0][PIX_W-1:0] tri_t;

    // [0] smallest, [2] largest
    function automatic tri_t sort3(input logic [PIX_W-1:0] a,
                                   input logic [PIX_W-1:0] b,
                                   input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] lo1, hi1, t;
        tri_t             s;
        lo1  = (a < b) ? a : b;
        hi1  = (a < b) ? b : a;
        s[0] = (lo1 < c) ? lo1 : c;
        t    = (lo1 < c) ? c : lo1;
        s[1] = (hi1 < t) ? hi1 : t;
        s[2] = (hi1 < t) ? t : hi1;
        return s;
    endfunction

    logic             s3_valid_reg, s4_valid_reg, out_valid_reg;
    tri_t [2:0]       cols_reg;
    logic             s3_last_reg;
    tri_t             cand_reg;
    logic             s4_last_reg;
    logic [PIX_W-1:0] median_reg;
    logic             last_reg;

    logic rdy3, rdy4, rdy5;
    tri_t [2:0] cols_now;
    tri_t       lows, mids, highs;
    tri_t       cand_now, fin_now;

    assign rdy5      = !out_valid_reg || results.ready;
    assign rdy4      = !s4_valid_reg || rdy5;
    assign rdy3      = !s3_valid_reg || rdy4;
    assign win_ready = rdy3;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            cols_now[k] = sort3(win.pix[3*k], win.pix[3*k+1], win.pix[3*k+2]);
    end

    // max of minima, median of middles, min of maxima
    always_comb
    begin
        lows        = sort3(cols_reg[0][0], cols_reg[1][0], cols_reg[2][0]);
        mids        = sort3(cols_reg[0][1], cols_reg[1][1], cols_reg[2][1]);
        highs       = sort3(cols_reg[0][2], cols_reg[1][2], cols_reg[2][2]);
        cand_now[0] = lows[2];
        cand_now[1] = mids[1];
        cand_now[2] = highs[0];
        fin_now     = sort3(cand_reg[0], cand_reg[1], cand_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
                s3_valid_reg <= win_valid;
            if (rdy4)
                s4_valid_reg <= s3_valid_reg;
            if (rdy5)
                out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && win_valid)
        begin
            cols_reg    <= cols_now;
            s3_last_reg <= win.last;
        end
        if (rdy4 && s3_valid_reg)
        begin
            cand_reg    <= cand_now;
            s4_last_reg <= s3_last_reg;
        end
        if (rdy5 && s4_valid_reg)
        begin
            median_reg <= fin_now[1];
            last_reg   <= s4_last_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.median     = median_reg;
    assign results.frame_last = last_reg;

endmodule

// ===== rtl/median_filter_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
//
// Streaming 3x3 median filter for 8-bit grayscale frames in raster order.
// One pixel is taken per clock while the result side keeps up; a result
// for interior pixel (r-1, c-1) leaves after pixel (r, c) is transferred,
// passing the line memory read register, the window register, and the
// sort network stages and output register. Border pixels give no
// result, and frame_last marks the last result of a frame. Rows r-1 and
// r-2 share one MAX_WIDTH x 16 memory with one read and one write port;
// its contents need no clearing. Writing image_width (0x0) or image_height
// (0x4) over APB restarts the frame; write them only while the block is idle.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    mf3_pixel_if.sink             pixels,
    mf3_result_if.source          results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    mf3_cfg_t cfg;
    logic     win_valid;
    logic     win_ready;
    mf3_win_t win;

    mf3_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mf3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pixels    (pixels),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win       (win)
    );

    mf3_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid),
        .win_ready (win_ready),
        .win       (win),
        .results   (results)
    );

`ifndef NO_ASSERTIONS
    // input back-pressure only when the whole pipeline is full behind a stalled output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !pixels.ready |-> (results.valid && !results.ready))
        else $error("pixel input stalled with room in the pipeline");

    a_width_rdback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[2] == REG_IMAGE_WIDTH))
        ##1 (paddr[2] == REG_IMAGE_WIDTH)
        |-> (prdata == APB_DATA_W'($past(pwdata[WIDTH_W-1:0]))))
        else $error("image_width readback differs from written value");

    a_height_rdback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[2] == REG_IMAGE_HEIGHT))
        ##1 (paddr[2] == REG_IMAGE_HEIGHT)
        |-> (prdata == APB_DATA_W'($past(pwdata[HEIGHT_W-1:0]))))
        else $error("image_height readback differs from written value");
`endif

endmodule
